>>> design/tmbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmbr_pkg: shared types and constants of the text message block reassembler
// Holds the status codes, the sequencer states, the store control bundle and
// the slot-to-address table.
// ----------------------------------------------------------------------------
package tmbr_pkg;

  localparam int unsigned BlockBytes = 13;
  localparam int unsigned StoreBytes = 52;
  localparam int unsigned NumRows    = StoreBytes / BlockBytes;
  localparam int unsigned AddrW      = $clog2(StoreBytes);
  localparam int unsigned RowW       = $clog2(NumRows);
  localparam int unsigned CntW       = $clog2(BlockBytes);

  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] PrintLo   = 8'h21;
  localparam logic [7:0] PrintHi   = 8'h7E;

  localparam logic [3:0] MaskOne   = 4'h1;
  localparam logic [3:0] MaskTwo   = 4'h3;
  localparam logic [3:0] MaskThree = 4'h7;
  localparam logic [3:0] MaskFour  = 4'hF;

  localparam logic [3:0] SlotRow0  = 4'h1;
  localparam logic [3:0] SlotRow1  = 4'h2;
  localparam logic [3:0] SlotRow2  = 4'h4;
  localparam logic [3:0] SlotRow3  = 4'h8;

  typedef enum logic [2:0] {
    StPending  = 3'd0,
    StRejected = 3'd1,
    StIgnored  = 3'd2,
    StCleared  = 3'd3,
    StChar     = 3'd4,
    StEmpty    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SWrite,
    SCheck,
    SScanRd,
    SScanCk,
    SEmitRd,
    SEmitOut,
    SResp
  } state_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             clr;
    logic             set_en;
    logic [RowW-1:0]  set_row;
  } store_ctrl_t;

  // First byte address of a row; row count NumRows gives the full length.
  function automatic logic [AddrW-1:0] row_start(input logic [RowW:0] row);
    logic [AddrW-1:0] a;
    unique case (row)
      3'd0:    a = 6'd0;
      3'd1:    a = 6'd13;
      3'd2:    a = 6'd26;
      3'd3:    a = 6'd39;
      3'd4:    a = 6'd52;
      default: a = 6'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

>>> design/tmbr_byte_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmbr_byte_unit: shared byte classifier
// Maps a non-printable byte to a space and flags a space byte.
// ----------------------------------------------------------------------------
module tmbr_byte_unit (
  input  wire logic [7:0] byte_i,
  output logic      [7:0] clean_o,
  output logic            is_space_o
);
  import tmbr_pkg::*;

  always_comb begin
    if (byte_i < PrintLo || byte_i > PrintHi) begin
      clean_o = SpaceChar;
    end else begin
      clean_o = byte_i;
    end
    is_space_o = (byte_i == SpaceChar);
  end

endmodule
`default_nettype wire

>>> design/tmbr_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmbr_store: 52-byte text store
// Byte-wide memory with registered read and one valid bit per 13-byte row.
// ----------------------------------------------------------------------------
module tmbr_store (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tmbr_pkg::store_ctrl_t                ctrl_i,
  input  wire logic [tmbr_pkg::AddrW-1:0]           raddr_i,
  output logic      [7:0]                           rdata_o,
  output logic      [tmbr_pkg::NumRows-1:0]         row_valid_o
);
  import tmbr_pkg::*;

  logic [7:0]         mem [StoreBytes];
  logic [7:0]         rdata_q;
  logic [NumRows-1:0] valid_q, valid_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[ctrl_i.waddr] <= ctrl_i.wdata;
    end
    rdata_q <= mem[raddr_i];
  end

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clr) begin
      valid_d = '0;
    end else if (ctrl_i.set_en) begin
      valid_d[ctrl_i.set_row] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign rdata_o     = rdata_q;
  assign row_valid_o = valid_q;

endmodule
`default_nettype wire

>>> design/text_message_block_reassembler_top.sv
`default_nettype none
// Latency: clear, zero-control and rejected items give their one result the cycle after
//   the transfer; a stored block is written byte by byte and checked, then gives a pending
//   status, an empty status for no text, or a scan that reads and checks each text byte,
//   followed by an empty status or by a read and an output step per emitted character.
// Throughput, output never stalled: a single-result item every cycle; a stored block
//   holds off new items until all its results are loaded. Reset clears control and row valid bits.
// ----------------------------------------------------------------------------
// text_message_block_reassembler_top: text message block reassembler
// Collects up to four 13-byte blocks into a text store and, once the block
// mask is complete, emits the trimmed text one character per transfer.
// ----------------------------------------------------------------------------
module text_message_block_reassembler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  control_byte_i,
  input  wire logic [63:0] payload_low_i,
  input  wire logic [39:0] payload_high_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [6:0]       text_char_o,
  output logic [5:0]       char_index_o,
  output logic             last_o
);
  import tmbr_pkg::*;

  localparam int unsigned PayW = 8 * BlockBytes;

  // Sequencer state and working registers
  state_e           state_q, state_d;
  logic [7:0]       acc_q, acc_d;
  logic             complete_q, complete_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [CntW-1:0]  wcnt_q, wcnt_d;
  logic [PayW-1:0]  pay_q, pay_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] first_q, first_d;
  logic [AddrW-1:0] last_q, last_d;
  logic             found_q, found_d;
  status_e          resp_q, resp_d;

  // Output register
  logic             ovalid_q, ovalid_d;
  status_e          ostatus_q, ostatus_d;
  logic [6:0]       ochar_q, ochar_d;
  logic [5:0]       oidx_q, oidx_d;
  logic             olast_q, olast_d;
  logic             out_free;

  // Store and byte unit
  store_ctrl_t        sctrl;
  logic [7:0]         rdata;
  logic [NumRows-1:0] row_valid;
  logic [7:0]         bu_in, bu_clean;
  logic               bu_space;

  // Decode of the incoming control byte
  logic [3:0]      mask_n, slot_n;
  logic            mask_ok, slot_ok;
  logic [RowW-1:0] slot_row;
  logic [7:0]      acc_new;

  // Length of the text: all leading filled rows
  logic [RowW:0]    lead_rows;
  logic [AddrW-1:0] text_len, text_len_m1;
  logic             found_now;

  tmbr_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sctrl),
    .raddr_i     (ptr_q),
    .rdata_o     (rdata),
    .row_valid_o (row_valid)
  );

  // Shared classifier: cleans payload bytes while writing, spots spaces while scanning
  assign bu_in = (state_q == SWrite) ? pay_q[7:0] : rdata;

  tmbr_byte_unit u_byte (
    .byte_i     (bu_in),
    .clean_o    (bu_clean),
    .is_space_o (bu_space)
  );

  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle) && out_free;

  always_comb begin
    mask_n  = control_byte_i[7:4];
    slot_n  = control_byte_i[3:0];
    mask_ok = (mask_n == MaskOne) || (mask_n == MaskTwo) ||
              (mask_n == MaskThree) || (mask_n == MaskFour);
    slot_ok  = 1'b1;
    slot_row = '0;
    unique case (slot_n)
      SlotRow0: slot_row = 2'd0;
      SlotRow1: slot_row = 2'd1;
      SlotRow2: slot_row = 2'd2;
      SlotRow3: slot_row = 2'd3;
      default:  slot_ok  = 1'b0;
    endcase
    acc_new = acc_q | control_byte_i;
  end

  always_comb begin
    if (!row_valid[0]) begin
      lead_rows = 3'd0;
    end else if (!row_valid[1]) begin
      lead_rows = 3'd1;
    end else if (!row_valid[2]) begin
      lead_rows = 3'd2;
    end else if (!row_valid[3]) begin
      lead_rows = 3'd3;
    end else begin
      lead_rows = 3'd4;
    end
    text_len    = row_start(lead_rows);
    text_len_m1 = text_len - 6'd1;
    found_now   = found_q || !bu_space;
  end

  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    complete_d = complete_q;
    row_d      = row_q;
    wcnt_d     = wcnt_q;
    pay_d      = pay_q;
    ptr_d      = ptr_q;
    first_d    = first_q;
    last_d     = last_q;
    found_d    = found_q;
    resp_d     = resp_q;

    ovalid_d  = ovalid_q && !out_ready_i;
    ostatus_d = ostatus_q;
    ochar_d   = ochar_q;
    oidx_d    = oidx_q;
    olast_d   = olast_q;

    sctrl         = '0;
    sctrl.waddr   = row_start({1'b0, row_q}) + AddrW'(wcnt_q);
    sctrl.wdata   = bu_clean;
    sctrl.set_row = row_q;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          // Single-result items load the output register directly
          ochar_d = '0;
          oidx_d  = '0;
          olast_d = 1'b1;
          if (mode_i) begin
            sctrl.clr = 1'b1;
            acc_d     = '0;
            ovalid_d  = 1'b1;
            ostatus_d = StCleared;
          end else if (control_byte_i == 8'h00) begin
            ovalid_d  = 1'b1;
            ostatus_d = StIgnored;
          end else if (!mask_ok || !slot_ok) begin
            sctrl.clr = 1'b1;
            acc_d     = '0;
            ovalid_d  = 1'b1;
            ostatus_d = StRejected;
          end else begin
            acc_d      = acc_new;
            complete_d = (acc_new[3:0] == acc_new[7:4]);
            row_d      = slot_row;
            wcnt_d     = '0;
            pay_d      = {payload_high_i, payload_low_i};
            state_d    = SWrite;
          end
        end
      end
      SWrite: begin
        // One cleaned byte a cycle; advance the payload shift register
        sctrl.we = 1'b1;
        pay_d    = pay_q >> 8;
        if (wcnt_q == CntW'(BlockBytes - 1)) begin
          sctrl.set_en = 1'b1;
          state_d      = SCheck;
        end else begin
          wcnt_d = wcnt_q + CntW'(1);
        end
      end
      SCheck: begin
        ptr_d   = '0;
        found_d = 1'b0;
        if (!complete_q) begin
          resp_d  = StPending;
          state_d = SResp;
        end else if (text_len == '0) begin
          resp_d  = StEmpty;
          state_d = SResp;
        end else begin
          state_d = SScanRd;
        end
      end
      SScanRd: begin
        state_d = SScanCk;
      end
      SScanCk: begin
        // Track first and last non-space position in one forward pass
        if (!bu_space) begin
          if (!found_q) begin
            first_d = ptr_q;
          end
          last_d  = ptr_q;
          found_d = 1'b1;
        end
        if (ptr_q == text_len_m1) begin
          if (found_now) begin
            ptr_d   = bu_space ? first_q : (found_q ? first_q : ptr_q);
            state_d = SEmitRd;
          end else begin
            resp_d  = StEmpty;
            state_d = SResp;
          end
        end else begin
          ptr_d   = ptr_q + AddrW'(1);
          state_d = SScanRd;
        end
      end
      SEmitRd: begin
        state_d = SEmitOut;
      end
      SEmitOut: begin
        // Hold the read byte until the output register frees up
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = StChar;
          ochar_d   = rdata[6:0];
          oidx_d    = ptr_q - first_q;
          olast_d   = (ptr_q == last_q);
          if (ptr_q == last_q) begin
            state_d = SIdle;
          end else begin
            ptr_d   = ptr_q + AddrW'(1);
            state_d = SEmitRd;
          end
        end
      end
      SResp: begin
        if (out_free) begin
          ovalid_d  = 1'b1;
          ostatus_d = resp_q;
          ochar_d   = '0;
          oidx_d    = '0;
          olast_d   = 1'b1;
          state_d   = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      acc_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_q    <= acc_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    complete_q <= complete_d;
    row_q      <= row_d;
    wcnt_q     <= wcnt_d;
    pay_q      <= pay_d;
    ptr_q      <= ptr_d;
    first_q    <= first_d;
    last_q     <= last_d;
    found_q    <= found_d;
    resp_q     <= resp_d;
    ostatus_q  <= ostatus_d;
    ochar_q    <= ochar_d;
    oidx_q     <= oidx_d;
    olast_q    <= olast_d;
  end

  assign out_valid_o  = ovalid_q;
  assign status_o     = ostatus_q;
  assign text_char_o  = ochar_q;
  assign char_index_o = oidx_q;
  assign last_o       = olast_q;

endmodule
`default_nettype wire

>>> tb/tb_text_message_block_reassembler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_text_message_block_reassembler_top: text block reassembly testbench
// Sends control/payload blocks to the reassembler, predicts every status and
// text character it should give, and compares each output transfer field by
// field. Directed corner cases come first, then random message sequences
// under changing sender and receiver idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module tb_text_message_block_reassembler_top;
  import tmbr_pkg::*;

  localparam int unsigned DrainCycles = 250;  // longest item: write, check, full scan and full emit
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxReports  = 10;

  typedef enum int {FillRaw, FillText, FillBlank, FillPadded} fill_e;

  typedef struct {
    status_e    status;
    logic [6:0] text_char;
    logic [5:0] char_index;
    logic       last;
  } text_result_t;

  // Tracks the store and the control accumulator and holds the results that
  // are still owed by the block, oldest first.
  class reassembly_scoreboard;
    logic [7:0]   ctl_acc;
    logic [7:0]   text_bytes [StoreBytes];
    text_result_t owed_q [$];
    int unsigned  mismatches;
    int unsigned  seen;

    function new();
      mismatches = 0;
      seen       = 0;
      wipe();
    endfunction

    function void wipe();
      ctl_acc = 8'h00;
      foreach (text_bytes[i]) text_bytes[i] = 8'h00;
    endfunction

    function void owe_single(status_e st);
      text_result_t r;
      r.status     = st;
      r.text_char  = '0;
      r.char_index = '0;
      r.last       = 1'b1;
      owed_q.push_back(r);
    endfunction

    function void fail(string msg);
      mismatches++;
      if (mismatches <= MaxReports) $display("mismatch: %s", msg);
    endfunction

    // Work out everything one accepted input transfer should produce.
    function void note_input(logic md, logic [7:0] ctl, logic [63:0] lo, logic [39:0] hi);
      logic [3:0]   mask;
      logic [3:0]   slot;
      logic [7:0]   c;
      int unsigned  base;
      int unsigned  len;
      int unsigned  first;
      int unsigned  stop;
      text_result_t r;
      if (md) begin
        wipe();
        owe_single(StCleared);
        return;
      end
      if (ctl == 8'h00) begin
        owe_single(StIgnored);
        return;
      end
      mask = ctl[7:4];
      slot = ctl[3:0];
      if (mask != MaskOne && mask != MaskTwo && mask != MaskThree && mask != MaskFour) begin
        wipe();
        owe_single(StRejected);
        return;
      end
      case (slot)
        SlotRow0: base = 0;
        SlotRow1: base = BlockBytes;
        SlotRow2: base = 2 * BlockBytes;
        SlotRow3: base = 3 * BlockBytes;
        default: begin
          wipe();
          owe_single(StRejected);
          return;
        end
      endcase
      for (int i = 0; i < BlockBytes; i++) begin
        c = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
        if (c < PrintLo || c > PrintHi) c = SpaceChar;
        text_bytes[base + i] = c;
      end
      ctl_acc = ctl_acc | ctl;
      if (ctl_acc[3:0] != ctl_acc[7:4]) begin
        owe_single(StPending);
        return;
      end
      // Text runs to the first unwritten byte; trim spaces on both ends.
      len = 0;
      while (len < StoreBytes && text_bytes[len] != 8'h00) len++;
      first = 0;
      while (first < len && text_bytes[first] == SpaceChar) first++;
      stop = len;
      while (stop > first && text_bytes[stop - 1] == SpaceChar) stop--;
      if (stop == first) begin
        owe_single(StEmpty);
        return;
      end
      for (int unsigned i = 0; i < stop - first; i++) begin
        r.status     = StChar;
        r.text_char  = text_bytes[first + i][6:0];
        r.char_index = i[5:0];
        r.last       = (first + i + 1 == stop);
        owed_q.push_back(r);
      end
    endfunction

    function void check_result(logic [2:0] st, logic [6:0] ch, logic [5:0] idx, logic lst);
      text_result_t e;
      seen++;
      if (owed_q.size() == 0) begin
        fail($sformatf("result %0d arrived with nothing owed: status %0d char %h index %0d last %0d",
                       seen, st, ch, idx, lst));
        return;
      end
      e = owed_q.pop_front();
      if (st !== e.status || ch !== e.text_char || idx !== e.char_index || lst !== e.last)
        fail($sformatf({"result %0d: status exp %0d got %0d, char exp %h got %h, ",
                        "index exp %0d got %0d, last exp %0d got %0d"},
                       seen, e.status, st, e.text_char, ch, e.char_index, idx, e.last, lst));
    endfunction

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        mode_i;
  logic [7:0]  control_byte_i;
  logic [63:0] payload_low_i;
  logic [39:0] payload_high_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [6:0]  text_char_o;
  logic [5:0]  char_index_o;
  logic        last_o;

  reassembly_scoreboard sb;

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned n_counted;
  bit          hold_req;

  text_message_block_reassembler_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .control_byte_i (control_byte_i),
    .payload_low_i  (payload_low_i),
    .payload_high_i (payload_high_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .text_char_o    (text_char_o),
    .char_index_o   (char_index_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: drive ready at the falling edge. A hold request holds ready low
  // until a counter loaded from HoldCycles runs out, so the block backs up into its input.
  initial begin : receiver
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Check every output transfer against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, text_char_o, char_index_o, last_o);
  end

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(PrintLo, PrintHi));
  endfunction

  function automatic void make_payload(input fill_e fill, output logic [63:0] lo,
                                       output logic [39:0] hi);
    logic [7:0] b;
    lo = '0;
    hi = '0;
    for (int i = 0; i < BlockBytes; i++) begin
      case (fill)
        FillRaw:    b = 8'($urandom_range(0, 255));
        FillText:   b = ($urandom_range(0, 7) == 0) ? SpaceChar : text_byte();
        FillBlank:  b = $urandom_range(0, 1) ? 8'($urandom_range(0, SpaceChar))
                                             : 8'($urandom_range(PrintHi + 1, 255));
        default:    b = (i < 3 || i > 9) ? SpaceChar : text_byte();
      endcase
      if (i < 8) lo[8*i +: 8] = b;
      else       hi[8*(i-8) +: 8] = b;
    end
  endfunction

  // Offer one item at the falling edge and hold it until the transfer.
  task automatic send_item(input logic md, input logic [7:0] ctl, input logic [63:0] lo,
                           input logic [39:0] hi);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= md;
    control_byte_i <= ctl;
    payload_low_i  <= lo;
    payload_high_i <= hi;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(md, ctl, lo, hi);
    n_counted++;
  endtask

  task automatic send_block(input logic [7:0] ctl, input fill_e fill);
    logic [63:0] lo;
    logic [39:0] hi;
    make_payload(fill, lo, hi);
    send_item(1'b0, ctl, lo, hi);
  endtask

  task automatic send_clear();
    send_item(1'b1, 8'($urandom_range(0, 255)), {$urandom, $urandom}, {8'($urandom), $urandom});
  endtask

  // Drop valid and wait until every owed result has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.owed() != 0) @(posedge clk_i);
  endtask

  // One message: blocks for each slot of the mask in random order, now and
  // then with a block missing or repeated.
  task automatic send_message();
    logic [3:0] mask;
    logic [3:0] slots [4];
    logic [3:0] tmp;
    int         n;
    int         j;
    fill_e      fill;
    case ($urandom_range(0, 3))
      0:       mask = MaskOne;
      1:       mask = MaskTwo;
      2:       mask = MaskThree;
      default: mask = MaskFour;
    endcase
    n = 0;
    for (int k = 0; k < 4; k++) begin
      if (mask[k]) begin
        slots[n] = 4'(1 << k);
        n++;
      end
    end
    for (int k = n - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = slots[k];
      slots[k] = slots[j];
      slots[j] = tmp;
    end
    if ($urandom_range(0, 1)) send_clear();
    fill = fill_e'($urandom_range(0, 3));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) != 0) send_block({mask, slots[k]}, fill);
      if ($urandom_range(0, 9) == 0) send_block({mask, slots[k]}, fill_e'($urandom_range(0, 3)));
    end
  endtask

  // Noise: clears, zero controls, malformed and mismatched control bytes.
  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_clear();
      1: send_block(8'h00, FillRaw);
      2: send_block(8'($urandom_range(0, 255)), FillRaw);
      3: send_block({MaskFour >> $urandom_range(0, 3), 4'(1 << $urandom_range(0, 3))},
                    fill_e'($urandom_range(0, 3)));
      default: send_block({MaskFour >> $urandom_range(0, 3), 4'($urandom_range(0, 15))},
                          FillText);
    endcase
  endtask

  task automatic run_random(input int unsigned upto);
    while (n_counted < upto) begin
      if ($urandom_range(0, 4) != 0) send_message();
      else send_noise();
    end
  endtask

  initial begin : main
    logic [63:0] edge_lo;
    logic [39:0] edge_hi;
    sb             = new();
    hold_req       = 1'b0;
    n_counted      = 0;
    snd_idle_pct   = 6;
    rcv_idle_pct   = 56;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = 1'b0;
    control_byte_i = 8'h00;
    payload_low_i  = '0;
    payload_high_i = '0;
    // Lowest and highest printable characters, alternating.
    edge_lo = {4{PrintHi, PrintLo}};
    edge_hi = {PrintLo, {2{PrintHi, PrintLo}}};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: clear, ignore, every reject path, empty messages,
    // full-length text, stale completions.
    send_item(1'b1, 8'hFF, '1, '1);
    send_block(8'h00, FillRaw);
    send_block(8'h21, FillText);
    send_block(8'h13, FillText);
    send_block(8'h10, FillText);
    send_block(8'hF0, FillText);
    send_block(8'h01, FillText);
    send_item(1'b0, {MaskOne, SlotRow0}, '1, '1);
    send_item(1'b0, {MaskOne, SlotRow0}, '0, '0);
    send_item(1'b1, 8'h00, '0, '0);
    send_block({MaskOne, SlotRow0}, FillPadded);
    send_clear();
    send_item(1'b0, {MaskFour, SlotRow3}, edge_lo, edge_hi);
    send_block({MaskFour, SlotRow2}, FillText);
    send_block({MaskFour, SlotRow1}, FillRaw);
    send_item(1'b0, {MaskFour, SlotRow0}, edge_lo, edge_hi);
    send_block({MaskFour, SlotRow2}, FillBlank);
    send_clear();
    send_block({MaskTwo, SlotRow1}, FillText);
    send_block({MaskTwo, SlotRow0}, FillPadded);
    send_block({MaskThree, SlotRow2}, FillText);
    send_block({MaskOne, SlotRow3}, FillText);
    send_block(8'h7F, FillText);
    send_block({MaskOne, SlotRow0}, FillRaw);
    drain();

    // Random part, sender mostly busy and receiver often stalled; midway the
    // receiver stops for a long stretch while items keep coming.
    run_random(50);
    hold_req = 1'b1;
    run_random(105);
    drain();

    snd_idle_pct = 56;
    rcv_idle_pct = 6;
    run_random(210);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(310);
    drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.owed() != 0) sb.fail($sformatf("%0d results never arrived", sb.owed()));
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
